FILE: hw/rtl/particle_heat_color_mapper_assert.svh
// Assertion macros shared by the particle heat color mapper checkers.
`ifndef PARTICLE_HEAT_COLOR_MAPPER_ASSERT_SVH
`define PARTICLE_HEAT_COLOR_MAPPER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define PHCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define PHCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/phcm_pkg.sv
// Shared constants, types and ramp helper functions for the heat color mapper.
package phcm_pkg;

  localparam int RAMP_ENTRIES_DEF = 256;

  localparam int TEMP_W     = 32;
  localparam int PRES_W     = 32;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int LUM_W      = 8;
  localparam int RATE_W     = 17;

  localparam logic [31:0]       SCALE_FLOOR = 32'd16384;
  localparam logic [RATE_W-1:0] RATE_ONE    = 17'd65536;
  localparam logic [LUM_W-1:0]  LUM_RESET   = 8'd255;
  localparam logic [RATE_W-1:0] RISE_RESET  = 17'd20972;
  localparam logic [RATE_W-1:0] FALL_RESET  = 17'd2621;

  // Alpha: floor(lum*(255+4p)/1275) via reciprocal, exact for products below 2^19.
  localparam int              ALPHA_STEPS_W = 8;
  localparam logic [10:0]     ALPHA_BASE    = 11'd255;
  localparam logic [16:0]     ALPHA_RECIP   = 17'd105269;
  localparam int              ALPHA_SHIFT   = 27;
  localparam logic [7:0]      ALPHA_MIN     = 8'd6;

  localparam int COLD_R = 56;
  localparam int COLD_G = 105;
  localparam int COLD_B = 255;
  localparam int WARM_R = 255;
  localparam int WARM_G = 170;
  localparam int WARM_B = 90;
  localparam int HOT_R  = 255;
  localparam int HOT_G  = 76;
  localparam int HOT_B  = 66;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMINOSITY = 2'd0,
    REG_RISE_RATE  = 2'd1,
    REG_FALL_RATE  = 2'd2
  } cfg_reg_t;

  // Denominator of ramp entry i for a ramp with last index m.
  function automatic int ramp_den(int i, int m);
    if (20 * i < 11 * m) begin
      return 11 * m;
    end
    return 9 * m;
  endfunction

  // Numerator of one channel of ramp entry i (cold -> warm -> hot).
  function automatic int ramp_num(int i, int m, int c, int w, int h);
    if (20 * i < 11 * m) begin
      return c * 11 * m + (w - c) * 20 * i;
    end
    return w * 9 * m + (h - w) * (20 * i - 11 * m);
  endfunction

endpackage

FILE: hw/rtl/phcm_if.sv
// Channel interfaces of the heat color mapper: particle in, color out, config write.
interface phcm_in_if
  import phcm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;
  logic                     last_in_frame;

  modport source (output valid, output temperature, output pressure, output last_in_frame,
                  input ready);
  modport sink   (input valid, input temperature, input pressure, input last_in_frame,
                  output ready);
endinterface

interface phcm_out_if
  import phcm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface phcm_cfg_if
  import phcm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/particle_heat_color_mapper.sv
// Top level of the particle heat color mapper: serial quantizers, ramp ROM, alpha, scales.
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+---------------------------------------------
//   in_ch    | in  | valid/ready | temperature, pressure (Q16.16), last_in_frame
//   out_ch   | out | valid/ready | red, green, blue, alpha (8 bits each)
//   cfg_ch   | in  | valid/ready | index (0 lum, 1 rise, 2 fall), data
//
// One particle at a time. After its input transfer an item passes through ST_CHK, ST_DIV,
// ST_ALPHA1, ST_ALPHA2 and ST_EMIT before its color shows on out_ch; in ST_DIV the two
// restoring quantizers produce one quotient bit per cycle.
// rst_n is synchronous, active low; scales and frame maxima come up at 0.25.
// A finished color sits in the output register while the next particle is taken; a
// stalled out_ch holds the following item in its last stage. cfg_ch is always ready.
module particle_heat_color_mapper
  import phcm_pkg::*;
#(
  parameter int RAMP_ENTRIES = RAMP_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  phcm_in_if.sink    in_ch,
  phcm_out_if.source out_ch,
  phcm_cfg_if.sink   cfg_ch
);

  localparam int RAMP_MAX = RAMP_ENTRIES - 1;
  localparam int TW       = $clog2(RAMP_ENTRIES);       // temperature quotient bits
  localparam int PW       = ALPHA_STEPS_W;              // pressure quotient bits
  localparam int MAXW     = (TW > PW) ? TW : PW;        // serial steps per item
  localparam int STEP_W   = $clog2(MAXW);
  localparam int NTW      = 32 + TW;                    // temperature dividend width
  localparam int NPW      = 32 + PW;                    // pressure dividend width

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHK    = 6'b000010,   // overflow check, scale targets
    ST_DIV    = 6'b000100,   // one quotient bit per cycle
    ST_ALPHA1 = 6'b001000,   // ROM read, luminosity product
    ST_ALPHA2 = 6'b010000,   // reciprocal multiply, clamp
    ST_EMIT   = 6'b100000    // wait for the output register
  } state_t;

  // ------------------------------------------------------------------
  // Constant color ramp, worked out at elaboration
  // ------------------------------------------------------------------
  logic [3*COLOR_W-1:0] ramp_rom [RAMP_ENTRIES];

  for (genvar gi = 0; gi < RAMP_ENTRIES; gi++) begin : g_ramp
    localparam int DEN   = ramp_den(gi, RAMP_MAX);
    localparam int R_VAL = ramp_num(gi, RAMP_MAX, COLD_R, WARM_R, HOT_R) / DEN;
    localparam int G_VAL = ramp_num(gi, RAMP_MAX, COLD_G, WARM_G, HOT_G) / DEN;
    localparam int B_VAL = ramp_num(gi, RAMP_MAX, COLD_B, WARM_B, HOT_B) / DEN;
    assign ramp_rom[gi] = {COLOR_W'(R_VAL), COLOR_W'(G_VAL), COLOR_W'(B_VAL)};
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  state_t              state_r;
  logic [STEP_W-1:0]   step_r;

  logic [LUM_W-1:0]    lum_r;
  logic [RATE_W-1:0]   rise_r;
  logic [RATE_W-1:0]   fall_r;

  logic [31:0]         tscale_r;
  logic [31:0]         pscale_r;
  logic [31:0]         tmax_r;
  logic [31:0]         pmax_r;

  // serial dividers: partial remainder, dividend low bits, quotient, divisor
  logic [31:0]         trem_r;
  logic [TW-1:0]       tlow_r;
  logic [TW-1:0]       tquo_r;
  logic [31:0]         tdiv_r;
  logic                tovf_r;
  logic [31:0]         prem_r;
  logic [PW-1:0]       plow_r;
  logic [PW-1:0]       pquo_r;
  logic [31:0]         pdiv_r;
  logic                povf_r;

  logic                last_r;
  logic                upd_r;
  logic                tup_r;
  logic                pup_r;
  logic [31:0]         tgap_r;
  logic [31:0]         pgap_r;
  logic [RATE_W-1:0]   trate_r;
  logic [RATE_W-1:0]   prate_r;
  logic [31:0]         tstep_r;
  logic [31:0]         pstep_r;

  logic [18:0]         aprod_r;
  logic [3*COLOR_W-1:0] rgb_r;
  logic [COLOR_W-1:0]  alpha_r;

  logic                out_valid_r;
  logic [COLOR_W-1:0]  out_red_r;
  logic [COLOR_W-1:0]  out_green_r;
  logic [COLOR_W-1:0]  out_blue_r;
  logic [COLOR_W-1:0]  out_alpha_r;

  // ------------------------------------------------------------------
  // Combinational helpers
  // ------------------------------------------------------------------
  logic                in_xfer;
  logic                emit_load;
  logic                t_pos;
  logic                p_pos;
  logic [NTW-1:0]      tnum;
  logic [NPW-1:0]      pnum;
  logic [31:0]         tmax_nxt;
  logic [31:0]         pmax_nxt;

  logic [32:0]         tshift;
  logic [32:0]         tdiff;
  logic [32:0]         pshift;
  logic [32:0]         pdiff;

  logic [31:0]         ttarget;
  logic [31:0]         ptarget;
  logic                tup_nxt;
  logic                pup_nxt;
  logic [RATE_W-1:0]   trate_sel;
  logic [RATE_W-1:0]   prate_sel;
  logic [48:0]         tstep_prod;
  logic [48:0]         pstep_prod;
  logic [32:0]         tsum;
  logic [32:0]         psum;

  logic [TW-1:0]       tidx;
  logic [PW-1:0]       pidx;
  logic [10:0]         aweight;
  logic [35:0]         aquo_prod;
  logic [COLOR_W-1:0]  aquo;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Dividends: value * steps, zero for values at or below zero.
  assign t_pos = !in_ch.temperature[31] && (in_ch.temperature != '0);
  assign p_pos = !in_ch.pressure[31] && (in_ch.pressure != '0);
  assign tnum  = t_pos ? NTW'(in_ch.temperature[30:0]) * NTW'(RAMP_MAX) : '0;
  assign pnum  = p_pos ? (NPW'(in_ch.pressure[30:0]) << PW) - NPW'(in_ch.pressure[30:0])
                       : '0;

  // Frame maxima include the current particle.
  always_comb begin
    tmax_nxt = tmax_r;
    pmax_nxt = pmax_r;
    if (t_pos && (32'(in_ch.temperature) > tmax_r)) begin
      tmax_nxt = 32'(in_ch.temperature);
    end
    if (p_pos && (32'(in_ch.pressure) > pmax_r)) begin
      pmax_nxt = 32'(in_ch.pressure);
    end
  end

  // One restoring step each.
  assign tshift = {trem_r, tlow_r[TW-1]};
  assign tdiff  = tshift - {1'b0, tdiv_r};
  assign pshift = {prem_r, plow_r[PW-1]};
  assign pdiff  = pshift - {1'b0, pdiv_r};

  // Scale adaptation toward max(0.25, frame max).
  assign ttarget   = (tmax_r < SCALE_FLOOR) ? SCALE_FLOOR : tmax_r;
  assign ptarget   = (pmax_r < SCALE_FLOOR) ? SCALE_FLOOR : pmax_r;
  assign tup_nxt   = ttarget > tscale_r;
  assign pup_nxt   = ptarget > pscale_r;

  always_comb begin
    trate_sel = tup_nxt ? rise_r : fall_r;
    prate_sel = pup_nxt ? rise_r : fall_r;
    if (trate_sel > RATE_ONE) begin
      trate_sel = RATE_ONE;
    end
    if (prate_sel > RATE_ONE) begin
      prate_sel = RATE_ONE;
    end
  end

  assign tstep_prod = 49'(tgap_r) * 49'(trate_r);
  assign pstep_prod = 49'(pgap_r) * 49'(prate_r);
  assign tsum       = {1'b0, tscale_r} + {1'b0, tstep_r};
  assign psum       = {1'b0, pscale_r} + {1'b0, pstep_r};

  // Final indices: overflow or too-large quotient pins to the top step.
  always_comb begin
    if (tovf_r || (32'(tquo_r) > 32'(RAMP_MAX))) begin
      tidx = TW'(RAMP_MAX);
    end else begin
      tidx = tquo_r;
    end
    pidx = povf_r ? '1 : pquo_r;
  end

  assign aweight   = ALPHA_BASE + {1'b0, pidx, 2'b00};
  assign aquo_prod = 36'(aprod_r) * 36'(ALPHA_RECIP);
  assign aquo      = aquo_prod[ALPHA_SHIFT +: COLOR_W];

  // ------------------------------------------------------------------
  // Configuration
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lum_r  <= LUM_RESET;
      rise_r <= RISE_RESET;
      fall_r <= FALL_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_LUMINOSITY: lum_r  <= cfg_ch.data[LUM_W-1:0];
        REG_RISE_RATE:  rise_r <= cfg_ch.data[RATE_W-1:0];
        REG_FALL_RATE:  fall_r <= cfg_ch.data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Sequencer, scales and frame maxima
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      tscale_r <= SCALE_FLOOR;
      pscale_r <= SCALE_FLOOR;
      tmax_r   <= SCALE_FLOOR;
      pmax_r   <= SCALE_FLOOR;
      last_r   <= 1'b0;
      upd_r    <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            tmax_r  <= tmax_nxt;
            pmax_r  <= pmax_nxt;
            last_r  <= in_ch.last_in_frame;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          // targets are latched below; maxima restart for the next frame
          upd_r <= last_r;
          if (last_r) begin
            tmax_r <= SCALE_FLOOR;
            pmax_r <= SCALE_FLOOR;
          end
          step_r  <= STEP_W'(MAXW - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          // gap*rate lands on the first step, the scales move on the second
          if (upd_r && (step_r == STEP_W'(MAXW - 2))) begin
            tscale_r <= tup_r ? (tsum[32] ? '1 : tsum[31:0]) : tscale_r - tstep_r;
            pscale_r <= pup_r ? (psum[32] ? '1 : psum[31:0]) : pscale_r - pstep_r;
            upd_r    <= 1'b0;
          end
          if (step_r == '0) begin
            state_r <= ST_ALPHA1;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_ALPHA1: state_r <= ST_ALPHA2;
        ST_ALPHA2: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (emit_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Datapath (no reset needed)
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      trem_r <= tnum[NTW-1:TW];
      tlow_r <= tnum[TW-1:0];
      prem_r <= pnum[NPW-1:PW];
      plow_r <= pnum[PW-1:0];
      tdiv_r <= (tscale_r < SCALE_FLOOR) ? SCALE_FLOOR : tscale_r;
      pdiv_r <= (pscale_r < SCALE_FLOOR) ? SCALE_FLOOR : pscale_r;
      tquo_r <= '0;
      pquo_r <= '0;
    end

    if (state_r == ST_CHK) begin
      // a high part at or above the divisor means the quotient needs more bits
      tovf_r  <= trem_r >= tdiv_r;
      povf_r  <= prem_r >= pdiv_r;
      tup_r   <= tup_nxt;
      pup_r   <= pup_nxt;
      tgap_r  <= tup_nxt ? ttarget - tscale_r : tscale_r - ttarget;
      pgap_r  <= pup_nxt ? ptarget - pscale_r : pscale_r - ptarget;
      trate_r <= trate_sel;
      prate_r <= prate_sel;
    end

    if (state_r == ST_DIV) begin
      if (32'(step_r) < 32'(TW)) begin
        tlow_r <= tlow_r << 1;
        if (!tdiff[32]) begin
          trem_r <= tdiff[31:0];
          tquo_r <= {tquo_r[TW-2:0], 1'b1};
        end else begin
          trem_r <= tshift[31:0];
          tquo_r <= {tquo_r[TW-2:0], 1'b0};
        end
      end
      if (32'(step_r) < 32'(PW)) begin
        plow_r <= plow_r << 1;
        if (!pdiff[32]) begin
          prem_r <= pdiff[31:0];
          pquo_r <= {pquo_r[PW-2:0], 1'b1};
        end else begin
          prem_r <= pshift[31:0];
          pquo_r <= {pquo_r[PW-2:0], 1'b0};
        end
      end
      if (step_r == STEP_W'(MAXW - 1)) begin
        tstep_r <= tstep_prod[47:16];
        pstep_r <= pstep_prod[47:16];
      end
    end

    if (state_r == ST_ALPHA1) begin
      rgb_r   <= ramp_rom[tidx];
      aprod_r <= 19'(lum_r) * 19'(aweight);
    end

    if (state_r == ST_ALPHA2) begin
      alpha_r <= (aquo < ALPHA_MIN) ? ALPHA_MIN : aquo;
    end
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_red_r   <= rgb_r[3*COLOR_W-1:2*COLOR_W];
      out_green_r <= rgb_r[2*COLOR_W-1:COLOR_W];
      out_blue_r  <= rgb_r[COLOR_W-1:0];
      out_alpha_r <= alpha_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue  = out_blue_r;
  assign out_ch.alpha = out_alpha_r;

endmodule

FILE: hw/rtl/phcm_checker.sv
// Port-level checker for the heat color mapper and its bind to the top level.
`include "particle_heat_color_mapper_assert.svh"

module phcm_checker
  import phcm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] out_red,
  input logic [COLOR_W-1:0] out_green,
  input logic [COLOR_W-1:0] out_blue,
  input logic [COLOR_W-1:0] out_alpha
);

  `PHCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out valid dropped")
  `PHCM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha), "out payload moved")
  `PHCM_ASSERT_SAME(a_alpha_min, out_valid, out_alpha >= ALPHA_MIN, "alpha below floor")
  `PHCM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken")
  `PHCM_ASSERT_SAME(a_emit_idle, $rose(out_valid), in_ready, "result shown while busy")

endmodule

bind particle_heat_color_mapper phcm_checker u_phcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red),
  .out_green (out_ch.green),
  .out_blue  (out_ch.blue),
  .out_alpha (out_ch.alpha)
);

FILE: tb/sv/phcm_color_checker.sv
// Checker for the heat color mapper: watches all channels, predicts colors, compares.
module phcm_color_checker
  import phcm_pkg::*;
#(
  parameter int RAMP_ENTRIES = RAMP_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  phcm_in_if   in_ch,
  phcm_out_if  out_ch,
  phcm_cfg_if  cfg_ch,
  output int   fail_count,
  output int   colors_pending
);

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } rgba_t;

  rgba_t color_queue[$];

  logic [LUM_W-1:0]  lum;
  logic [RATE_W-1:0] rise;
  logic [RATE_W-1:0] fall;
  logic [31:0]       temp_scale;
  logic [31:0]       pres_scale;
  logic [31:0]       temp_peak;
  logic [31:0]       pres_peak;

  // Quantize against a scale floored at 0.25, capped at steps.
  function automatic logic [31:0] level_of(input logic signed [31:0] v,
                                           input logic [31:0] scale,
                                           input int unsigned steps);
    longint unsigned vv;
    longint unsigned div;
    longint unsigned q;
    if (v <= 0) return '0;
    vv  = {32'd0, v};
    div = (scale < SCALE_FLOOR) ? {32'd0, SCALE_FLOOR} : {32'd0, scale};
    q   = (vv * steps) / div;
    return (q > steps) ? steps : q[31:0];
  endfunction

  // One channel of the cold -> warm -> hot ramp.
  function automatic logic [COLOR_W-1:0] ramp_level(input int unsigned idx,
                                                    input longint c,
                                                    input longint w,
                                                    input longint h);
    longint m;
    longint ii;
    longint num;
    longint den;
    m  = RAMP_ENTRIES - 1;
    if (m < 1) m = 1;
    ii = idx;
    if (20 * ii < 11 * m) begin
      den = 11 * m;
      num = c * den + (w - c) * 20 * ii;
    end else begin
      den = 9 * m;
      num = w * den + (h - w) * (20 * ii - 11 * m);
    end
    if (num < 0) num = 0;
    return COLOR_W'(num / den);
  endfunction

  // Move a scale toward max(0.25, frame peak) by the rise or fall fraction.
  function automatic logic [31:0] settle_scale(input logic [31:0] cur,
                                               input logic [31:0] peak,
                                               input logic [RATE_W-1:0] up,
                                               input logic [RATE_W-1:0] down);
    logic [31:0]     goal;
    longint unsigned rate;
    longint unsigned gap;
    longint unsigned nxt;
    goal = (peak < SCALE_FLOOR) ? SCALE_FLOOR : peak;
    rate = (goal > cur) ? up : down;
    if (rate > RATE_ONE) rate = RATE_ONE;
    if (goal > cur) begin
      gap = goal - cur;
      nxt = cur + ((gap * rate) >> 16);
      return (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
    end
    gap = cur - goal;
    return cur - 32'((gap * rate) >> 16);
  endfunction

  task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                             input logic [COLOR_W-1:0] got, inout int errs);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    rgba_t             want;
    rgba_t             got;
    logic signed [31:0] t;
    logic signed [31:0] p;
    logic [31:0]       ti;
    logic [31:0]       pi;
    longint            a;
    int                errs;
    errs = 0;
    if (!rst_n) begin
      lum        = LUM_RESET;
      rise       = RISE_RESET;
      fall       = FALL_RESET;
      temp_scale = SCALE_FLOOR;
      pres_scale = SCALE_FLOOR;
      temp_peak  = SCALE_FLOOR;
      pres_peak  = SCALE_FLOOR;
      color_queue.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_LUMINOSITY: lum  = cfg_ch.data[LUM_W-1:0];
          REG_RISE_RATE:  rise = cfg_ch.data[RATE_W-1:0];
          REG_FALL_RATE:  fall = cfg_ch.data[RATE_W-1:0];
          default: ;
        endcase
      end

      // compare before predicting: a result cannot belong to this cycle's input
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha};
        if (color_queue.size() == 0) begin
          $error("color transfer with no expected color: r=%0d g=%0d b=%0d a=%0d",
                 got.red, got.green, got.blue, got.alpha);
          errs++;
        end else begin
          want = color_queue.pop_front();
          check_field("red",   want.red,   got.red,   errs);
          check_field("green", want.green, got.green, errs);
          check_field("blue",  want.blue,  got.blue,  errs);
          check_field("alpha", want.alpha, got.alpha, errs);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        t  = in_ch.temperature;
        p  = in_ch.pressure;
        ti = level_of(t, temp_scale, RAMP_ENTRIES - 1);
        pi = level_of(p, pres_scale, 255);
        a  = (longint'(lum) * (255 + 4 * longint'(pi))) / 1275;
        if (a < ALPHA_MIN) a = ALPHA_MIN;
        if (a > 255) a = 255;
        want.red   = ramp_level(ti, COLD_R, WARM_R, HOT_R);
        want.green = ramp_level(ti, COLD_G, WARM_G, HOT_G);
        want.blue  = ramp_level(ti, COLD_B, WARM_B, HOT_B);
        want.alpha = COLOR_W'(a);
        color_queue.push_back(want);

        if (t > 0 && unsigned'(t) > temp_peak) temp_peak = t;
        if (p > 0 && unsigned'(p) > pres_peak) pres_peak = p;
        if (in_ch.last_in_frame) begin
          temp_scale = settle_scale(temp_scale, temp_peak, rise, fall);
          pres_scale = settle_scale(pres_scale, pres_peak, rise, fall);
          temp_peak  = SCALE_FLOOR;
          pres_peak  = SCALE_FLOOR;
        end
      end
    end
    fail_count     <= fail_count + errs;
    colors_pending <= color_queue.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the heat color mapper: clock, reset, stimulus, output stalls, verdict.
module tb_top;
  import phcm_pkg::*;

  // Watchdog; several times what a correct run needs even under the longest stalls.
  localparam int unsigned LIMIT_CYCLES = 400000;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int unsigned LONG_HOLD    = 400;
  // Quiet time after the last color.
  localparam int unsigned SETTLE       = 40;
  // Items per random phase; four phases.
  localparam int unsigned PHASE_ITEMS  = 360;
  // Register index with no register behind it; a write must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  phcm_in_if  in_ch ();
  phcm_out_if out_ch ();
  phcm_cfg_if cfg_ch ();

  int          fail_count;
  int          colors_pending;
  int unsigned cycle_count = 0;

  // Stimulus-side knobs read by the receiver process.
  int phase_no = 0;
  bit calm     = 1'b0;

  particle_heat_color_mapper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  phcm_color_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .fail_count     (fail_count),
    .colors_pending (colors_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one particle and hold it until the transfer. valid stays high on return
  // so back-to-back items need no second assignment in the same step.
  task automatic push_particle(input logic signed [31:0] t, input logic signed [31:0] p,
                               input logic last);
    in_ch.valid         <= 1'b1;
    in_ch.temperature   <= t;
    in_ch.pressure      <= p;
    in_ch.last_in_frame <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic rest_input(input int unsigned n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering, wait until every expected color is out, then let the block
  // finish its frame bookkeeping before anything else happens.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (colors_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers (and optionally the unused index) back to back.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] lum_word,
                                input logic [CFG_DATA_W-1:0] rise_word,
                                input logic [CFG_DATA_W-1:0] fall_word,
                                input bit with_spare);
    logic [CFG_IDX_W-1:0]  idx_list [4];
    logic [CFG_DATA_W-1:0] val_list [4];
    int                    n;
    idx_list = '{REG_LUMINOSITY, REG_RISE_RATE, REG_FALL_RATE, REG_SPARE};
    val_list = '{lum_word, rise_word, fall_word, CFG_DATA_W'($urandom)};
    for (n = 0; n < (with_spare ? 4 : 3); n++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx_list[n];
      cfg_ch.data  <= val_list[n];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mix of zeros, negatives, values near the floor scale and wide magnitudes.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = $urandom;
      1:       v = '0;
      2:       v = -($urandom >> $urandom_range(0, 31));
      3, 4:    v = $urandom_range(0, 65536);
      default: v = $urandom >> $urandom_range(1, 31);
    endcase
    return v;
  endfunction

  // Random frames of 1 to 24 particles; the last one carries the frame mark,
  // with a rare stray mark inside a frame.
  task automatic run_frames(input int unsigned total);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    bit          gappy;
    logic        last;
    sent = 0;
    while (sent < total) begin
      len   = $urandom_range(1, 24);
      gappy = !calm && ($urandom_range(0, 2) != 0);
      for (k = 0; k < len && sent < total; k++) begin
        last = (k == len - 1) || ($urandom_range(0, 30) == 0);
        push_particle(pick_value(), pick_value(), last);
        sent++;
        if (gappy && $urandom_range(0, 3) == 0) rest_input($urandom_range(1, 17));
      end
    end
  endtask

  // Receiver: random ready bursts, one long hold-off at the start of phase 2,
  // always ready once the run turns calm.
  initial begin : color_sink
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && phase_no == 2) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  initial begin : particle_source
    int k;
    in_ch.valid         <= 1'b0;
    in_ch.temperature   <= '0;
    in_ch.pressure      <= '0;
    in_ch.last_in_frame <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_LUMINOSITY;
    cfg_ch.data         <= '0;
    rst_n               <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings, scales at 0.25.
    push_particle(32'sd0, 32'sd0, 1'b0);
    push_particle(-32'sd1, -32'sd1, 1'b0);
    push_particle(32'sh8000_0000, 32'sh8000_0000, 1'b0);        // most negative
    push_particle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);        // index capped
    push_particle(32'sd1, 32'sd1, 1'b0);
    push_particle(32'sd16383, 32'sd16383, 1'b0);                // just below full
    push_particle(32'sd16384, 32'sd16384, 1'b0);                // exactly full scale
    push_particle(32'sd16385, 32'sd16385, 1'b0);
    // around the cold-warm / warm-hot segment boundary
    for (k = 139; k <= 141; k++) begin
      push_particle((k * 16384 + 254) / 255, pick_value(), 1'b0);
    end
    // frame end with a huge peak: scales rise
    push_particle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    push_particle(32'sd16384, 32'sd16384, 1'b0);
    // negatives leave the peaks at the floor; scales fall back
    push_particle(-32'sd5, -32'sd5, 1'b1);
    push_particle(32'sh4000_0000, 32'sh0001_0000, 1'b0);
    push_particle(32'sh0000_8000, 32'sh7FFF_0000, 1'b1);
    push_particle(32'sh5555_5555, 32'shAAAA_AAAA, 1'b1);
    push_particle(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
    push_particle(32'sd0, 32'sd0, 1'b1);

    // Phase 1: dark, rise above one (acts as one), fall closes the whole gap.
    wait_drained();
    apply_settings(17'd0, 17'h1FFFF, RATE_ONE, 1'b0);
    phase_no = 1;
    run_frames(PHASE_ITEMS);

    // Phase 2: full brightness, scales never rise, fall above one. Long stall here.
    wait_drained();
    apply_settings(17'd255, 17'd0, 17'h1FFFF, 1'b0);
    phase_no = 2;
    run_frames(PHASE_ITEMS);

    // Phase 3: random settings; upper data bits on the luminosity write are junk,
    // plus a write to the unused index.
    wait_drained();
    apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 131071)),
                   CFG_DATA_W'($urandom_range(0, 131071)), 1'b1);
    phase_no = 3;
    run_frames(PHASE_ITEMS);

    // Phase 4: small luminosity, reset rates, no idling on either side.
    wait_drained();
    apply_settings(CFG_DATA_W'($urandom_range(0, 12)), RISE_RESET, FALL_RESET, 1'b0);
    phase_no = 4;
    calm     = 1'b1;
    run_frames(PHASE_ITEMS);

    wait_drained();
    if (fail_count == 0 && colors_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: particle_heat_color_mapper.f
+incdir+hw/rtl
hw/rtl/phcm_pkg.sv
hw/rtl/phcm_if.sv
hw/rtl/particle_heat_color_mapper.sv
hw/rtl/phcm_checker.sv
tb/sv/phcm_color_checker.sv
tb/sv/tb_top.sv
